[src/quad_motor_mixer_with_failover_top_assert.svh]
// Assertion macros shared by the mixer RTL.
`ifndef QUAD_MOTOR_MIXER_WITH_FAILOVER_TOP_ASSERT_SVH
`define QUAD_MOTOR_MIXER_WITH_FAILOVER_TOP_ASSERT_SVH

`define QMM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mixer check failed");

`define QMM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mixer check failed");

`endif

[src/qmm_pkg.sv]
// Constants, types and arithmetic helpers for the motor mixer.
package qmm_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W = 32;

  localparam logic [1:0] NO_FAILURE = 2'd0;

  localparam logic [1:0] CFG_FAILED_MOTOR = 2'd0;
  localparam logic [1:0] CFG_ARMED_OFFSET = 2'd1;
  localparam logic [1:0] CFG_SPEED_DIVISOR = 2'd2;

  localparam int SQ_X_W = 2 * ((31 + FRAC_BITS + 1) / 2);
  localparam int SQRT_W = SQ_X_W / 2;
  localparam int SQ_REM_W = SQRT_W + 2;
  localparam int SQ_PER = 4;
  localparam int SQ_STAGES = (SQRT_W + SQ_PER - 1) / SQ_PER;

  localparam int DIV_W = 16;
  localparam int NUM_W = DIV_W + FRAC_BITS;
  localparam int DIV_REM_W = DIV_W + 1;
  localparam int DIV_PER = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_PER - 1) / DIV_PER;

  localparam int NORM_E4 [16] = '{
    -5718, 4376, 5718, -4376,
    -3536, 3536, -3536, 3536,
    -2832, -2832, 2832, 2832,
    2500, 2500, 2500, 2500
  };

  typedef struct packed {
    logic [SQ_X_W-1:0] x;
    logic [SQ_REM_W-1:0] rem;
    logic [SQRT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DIV_REM_W-1:0] rem;
    logic [NUM_W-1:0] quo;
    logic neg;
  } div_st_t;

  function automatic logic signed [31:0] norm_coef(int idx);
    longint m;
    longint r;
    m = longint'(NORM_E4[idx]) * (longint'(1) <<< FRAC_BITS);
    r = (m < 0) ? -((-m + 5000) / 10000) : (m + 5000) / 10000;
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] s);
    logic signed [31:0] r;
    if (s > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (s < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t r;
    logic [SQ_REM_W-1:0] rs;
    logic [SQ_REM_W-1:0] trial;
    rs = {s.rem[SQ_REM_W-3:0], s.x[SQ_X_W-1 -: 2]};
    trial = {s.root, 2'b01};
    r.x = s.x << 2;
    if (rs >= trial) begin
      r.rem = rs - trial;
      r.root = {s.root[SQRT_W-2:0], 1'b1};
    end else begin
      r.rem = rs;
      r.root = {s.root[SQRT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_st_t div_step(div_st_t s, logic [DIV_W-1:0] d);
    div_st_t r;
    logic [DIV_REM_W-1:0] rs;
    rs = {s.rem[DIV_W-1:0], s.num[NUM_W-1]};
    r.num = s.num << 1;
    r.neg = s.neg;
    if (rs >= {1'b0, d}) begin
      r.rem = rs - {1'b0, d};
      r.quo = {s.quo[NUM_W-2:0], 1'b1};
    end else begin
      r.rem = rs;
      r.quo = {s.quo[NUM_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[src/qmm_if.sv]
// Request channel interfaces for the mixer: wrench/load input and mix output.
interface qmm_wrench_if;
  logic valid;
  logic ready;
  logic mode;
  logic [3:0] coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] roll_torque;
  logic signed [31:0] pitch_torque;
  logic signed [31:0] yaw_torque;
  logic signed [31:0] thrust_cmd;
  modport source(output valid, mode, coef_index, coef_value, roll_torque, pitch_torque,
                 yaw_torque, thrust_cmd, input ready);
  modport sink(input valid, mode, coef_index, coef_value, roll_torque, pitch_torque,
               yaw_torque, thrust_cmd, output ready);
endinterface

interface qmm_mix_if;
  logic valid;
  logic ready;
  logic signed [31:0] throttle_m0;
  logic signed [31:0] throttle_m1;
  logic signed [31:0] throttle_m2;
  logic signed [31:0] throttle_m3;
  logic signed [31:0] norm_roll;
  logic signed [31:0] norm_pitch;
  logic signed [31:0] norm_yaw;
  logic signed [31:0] norm_thrust;
  logic [3:0] root_clamped;
  modport source(output valid, throttle_m0, throttle_m1, throttle_m2, throttle_m3,
                 norm_roll, norm_pitch, norm_yaw, norm_thrust, root_clamped, input ready);
  modport sink(input valid, throttle_m0, throttle_m1, throttle_m2, throttle_m3,
               norm_roll, norm_pitch, norm_yaw, norm_thrust, root_clamped, output ready);
endinterface

[src/quad_motor_mixer_with_failover_top.sv]
// Pipelined quadrotor mixer with single-motor failover.
//
//   channel  direction  carries
//   in_ch    sink       coefficient load or wrench sample request
//   out_ch   source     throttles, normalized wrench and clamp flags
//   cfg_*    write      failed motor, armed offset, speed divisor
//
// One request is taken per cycle while the pipeline is not held.
// The depth comes from the 24-step square root (6 stages) and the 32-step
// restoring divider (8 stages) per motor, plus multiply and sum stages.
// Coefficient loads are written on acceptance and produce no result.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears valid bits and configuration; the coefficient store is not reset.
module quad_motor_mixer_with_failover_top
  import qmm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [15:0] cfg_wdata,
  qmm_wrench_if.sink in_ch,
  qmm_mix_if.source out_ch
);

  `include "quad_motor_mixer_with_failover_top_assert.svh"

  logic [1:0] fail_idx;
  logic [15:0] armed_speed_offset;
  logic [15:0] speed_divisor;
  logic [DIV_W-1:0] div_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_idx <= NO_FAILURE;
      armed_speed_offset <= '0;
      speed_divisor <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAILED_MOTOR: fail_idx <= cfg_wdata[1:0];
        CFG_ARMED_OFFSET: armed_speed_offset <= cfg_wdata;
        CFG_SPEED_DIVISOR: speed_divisor <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign div_eff = (speed_divisor == '0) ? DIV_W'(1) : speed_divisor;

  logic vo;
  logic adv;
  logic accept;

  assign adv = !vo || out_ch.ready;
  assign in_ch.ready = adv;
  assign accept = in_ch.valid && adv;

  logic signed [31:0] store [16];

  always_ff @(posedge clk) begin
    if (accept && !in_ch.mode) begin
      store[in_ch.coef_index] <= in_ch.coef_value;
    end
  end

  // Stage 1: sixteen products.
  logic signed [31:0] opd [4];
  logic signed [63:0] prod [4][4];
  logic v1;

  always_comb begin
    opd[0] = in_ch.roll_torque;
    opd[1] = in_ch.pitch_torque;
    opd[2] = (fail_idx != NO_FAILURE) ? in_ch.thrust_cmd : in_ch.yaw_torque;
    opd[3] = (fail_idx != NO_FAILURE) ? 32'sd0 : in_ch.thrust_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid && in_ch.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod[i][j] <= store[i*4+j] * opd[j];
        end
      end
    end
  end

  // Stage 2: row sums, failover scatter, square root seeds.
  logic signed [31:0] part [4];
  logic signed [31:0] sq [MOTOR_COUNT];
  sqrt_st_t sq_seed [MOTOR_COUNT];
  logic [3:0] flg2;
  logic v2;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      part[i] = sat32((66'(prod[i][0]) + 66'(prod[i][1]) + 66'(prod[i][2])
                      + 66'(prod[i][3])) >>> FRAC_BITS);
    end
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      if (fail_idx != NO_FAILURE && 2'(m) == fail_idx) begin
        sq[m] = 32'sd0;
      end else if (fail_idx != NO_FAILURE && 2'(m) > fail_idx) begin
        sq[m] = part[(m + 3) % 4];
      end else begin
        sq[m] = part[m];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        flg2[m] <= sq[m][31];
        sq_seed[m].x <= sq[m][31] ? '0 : (SQ_X_W'(sq[m][30:0]) << FRAC_BITS);
        sq_seed[m].rem <= '0;
        sq_seed[m].root <= '0;
      end
    end
  end

  // Square root stages.
  sqrt_st_t sq_pipe [SQ_STAGES][MOTOR_COUNT];
  logic [3:0] sq_flg [SQ_STAGES];
  logic sq_v [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    sqrt_st_t st_in [MOTOR_COUNT];
    sqrt_st_t st_out [MOTOR_COUNT];
    logic [3:0] flg_in;
    logic v_in;

    if (k == 0) begin : g_first
      assign st_in = sq_seed;
      assign flg_in = flg2;
      assign v_in = v2;
    end else begin : g_next
      assign st_in = sq_pipe[k-1];
      assign flg_in = sq_flg[k-1];
      assign v_in = sq_v[k-1];
    end

    always_comb begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        st_out[m] = st_in[m];
        for (int s = 0; s < SQ_PER; s++) begin
          if (k * SQ_PER + s < SQRT_W) begin
            st_out[m] = sqrt_step(st_out[m]);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (adv) begin
        sq_v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_pipe[k] <= st_out;
        sq_flg[k] <= flg_in;
      end
    end
  end

  // Offset subtraction and divider seeds.
  div_st_t dv_seed [MOTOR_COUNT];
  logic [3:0] flg3;
  logic v3;
  logic signed [NUM_W+1:0] num [MOTOR_COUNT];

  always_comb begin
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      num[m] = signed'((NUM_W+2)'(sq_pipe[SQ_STAGES-1][m].root))
             - signed'((NUM_W+2)'({armed_speed_offset, {FRAC_BITS{1'b0}}}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= sq_v[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flg3 <= sq_flg[SQ_STAGES-1];
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        dv_seed[m].neg <= num[m][NUM_W+1];
        dv_seed[m].num <= num[m][NUM_W+1] ? NUM_W'(-num[m]) : num[m][NUM_W-1:0];
        dv_seed[m].rem <= '0;
        dv_seed[m].quo <= '0;
      end
    end
  end

  // Divider stages.
  div_st_t dv_pipe [DIV_STAGES][MOTOR_COUNT];
  logic [3:0] dv_flg [DIV_STAGES];
  logic dv_v [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    div_st_t st_in [MOTOR_COUNT];
    div_st_t st_out [MOTOR_COUNT];
    logic [3:0] flg_in;
    logic v_in;

    if (k == 0) begin : g_first
      assign st_in = dv_seed;
      assign flg_in = flg3;
      assign v_in = v3;
    end else begin : g_next
      assign st_in = dv_pipe[k-1];
      assign flg_in = dv_flg[k-1];
      assign v_in = dv_v[k-1];
    end

    always_comb begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        st_out[m] = st_in[m];
        for (int s = 0; s < DIV_PER; s++) begin
          if (k * DIV_PER + s < NUM_W) begin
            st_out[m] = div_step(st_out[m], div_eff);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (adv) begin
        dv_v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_pipe[k] <= st_out;
        dv_flg[k] <= flg_in;
      end
    end
  end

  // Sign and saturation of the throttles.
  logic signed [31:0] thr [MOTOR_COUNT];
  logic [3:0] flg4;
  logic v4;
  logic signed [65:0] qv [MOTOR_COUNT];

  always_comb begin
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      qv[m] = signed'(66'(dv_pipe[DIV_STAGES-1][m].quo));
      if (dv_pipe[DIV_STAGES-1][m].neg) begin
        qv[m] = -qv[m];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= dv_v[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flg4 <= dv_flg[DIV_STAGES-1];
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        thr[m] <= sat32(qv[m]);
      end
    end
  end

  // Normalization products.
  logic signed [31:0] rom [16];
  logic signed [63:0] nprod [4][4];
  logic signed [31:0] thr5 [MOTOR_COUNT];
  logic [3:0] flg5;
  logic v5;

  for (genvar e = 0; e < 16; e++) begin : g_rom
    assign rom[e] = norm_coef(e);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flg5 <= flg4;
      thr5 <= thr;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          nprod[i][j] <= rom[i*4+j] * thr[j];
        end
      end
    end
  end

  // Output register.
  logic signed [31:0] nsum [4];
  logic signed [31:0] thr_o [MOTOR_COUNT];
  logic signed [31:0] norm_o [4];
  logic [3:0] flg_o;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nsum[i] = sat32((66'(nprod[i][0]) + 66'(nprod[i][1]) + 66'(nprod[i][2])
                      + 66'(nprod[i][3])) >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (adv) begin
      vo <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      thr_o <= thr5;
      norm_o <= nsum;
      flg_o <= flg5;
    end
  end

  assign out_ch.valid = vo;
  assign out_ch.throttle_m0 = thr_o[0];
  assign out_ch.throttle_m1 = thr_o[1];
  assign out_ch.throttle_m2 = thr_o[2];
  assign out_ch.throttle_m3 = thr_o[3];
  assign out_ch.norm_roll = norm_o[0];
  assign out_ch.norm_pitch = norm_o[1];
  assign out_ch.norm_yaw = norm_o[2];
  assign out_ch.norm_thrust = norm_o[3];
  assign out_ch.root_clamped = flg_o;

  `QMM_ASSERT_NEXT(a_load_no_result, accept && !in_ch.mode, !v1)
  `QMM_ASSERT_NOW(a_failed_not_flagged, vo && fail_idx != NO_FAILURE, !flg_o[fail_idx])
  `QMM_ASSERT_NOW(a_div_rem_bound, dv_v[DIV_STAGES-1], dv_pipe[DIV_STAGES-1][0].rem < 17'(div_eff))
  `QMM_ASSERT_NEXT(a_hold_on_stall, !adv, vo)

endmodule

[tb/sv/qmm_tb_if.sv]
`timescale 1ns / 100ps
// Testbench result record type for the mixer output channel.
package qmm_tb_types;
  typedef struct {
    logic signed [31:0] thr [4];
    logic signed [31:0] nrm [4];
    logic [3:0] clamp;
  } mix_result_t;
endpackage

[tb/sv/quad_motor_mixer_with_failover_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the quad motor mixer: directed and random requests.
module quad_motor_mixer_with_failover_top_tb;
  import qmm_pkg::*;
  import qmm_tb_types::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;
  qmm_wrench_if in_ch();
  qmm_mix_if out_ch();

  quad_motor_mixer_with_failover_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  longint store [16];
  longint rom [16];
  logic [1:0] fail_sel;
  longint arm_off;
  longint divisor;
  mix_result_t expected_mixes [$];
  int errors;
  int mixes_seen;
  int wrenches_sent;
  int cycles;
  bit sink_stall_on;
  bit src_idle_on;
  bit long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Floored Q dot product; the fraction bits are summed apart so the total cannot overflow.
  function automatic longint dot_floor(longint a [4], longint b [4], int n);
    longint p;
    longint hi;
    longint lo;
    hi = 0;
    lo = 0;
    for (int i = 0; i < n; i++) begin
      p = a[i] * b[i];
      hi += p >>> 16;
      lo += p & 64'hffff;
    end
    return clip32(hi + (lo >>> 16));
  endfunction

  function automatic longint isqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic mix_result_t predict_mix(longint w [4]);
    mix_result_t m;
    longint sq [4];
    longint th [4];
    longint row [4];
    longint red [4];
    longint spd;
    longint nv;
    int k;
    k = 0;
    red = '{w[0], w[1], w[3], 0};
    for (int i = 0; i < 4; i++) begin
      if (fail_sel != NO_FAILURE) begin
        if (i == fail_sel) begin
          sq[i] = 0;
        end else begin
          for (int j = 0; j < 4; j++) row[j] = store[k*4+j];
          sq[i] = dot_floor(row, red, 3);
          k++;
        end
      end else begin
        for (int j = 0; j < 4; j++) row[j] = store[i*4+j];
        sq[i] = dot_floor(row, w, 4);
      end
    end
    m.clamp = 4'd0;
    for (int i = 0; i < 4; i++) begin
      spd = 0;
      if (sq[i] < 0) m.clamp[i] = 1'b1;
      else spd = isqrt(longint'(sq[i]) << 16);
      th[i] = clip32((spd - (arm_off << 16)) / (divisor == 0 ? 1 : divisor));
      m.thr[i] = th[i][31:0];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) row[j] = rom[i*4+j];
      nv = dot_floor(row, th, 4);
      m.nrm[i] = nv[31:0];
    end
    return m;
  endfunction

  task automatic send_request(bit md, logic [3:0] idx, logic [31:0] cv, logic [31:0] r,
                              logic [31:0] p, logic [31:0] y, logic [31:0] t);
    longint w [4];
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= md;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= cv;
    in_ch.roll_torque <= r;
    in_ch.pitch_torque <= p;
    in_ch.yaw_torque <= y;
    in_ch.thrust_cmd <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!md) begin
      store[idx] = longint'(signed'(cv));
    end else begin
      w[0] = longint'(signed'(r));
      w[1] = longint'(signed'(p));
      w[2] = longint'(signed'(y));
      w[3] = longint'(signed'(t));
      expected_mixes.push_back(predict_mix(w));
      wrenches_sent++;
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    mix_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      mixes_seen++;
      if (expected_mixes.size() == 0) begin
        $display("%0t unexpected mix result", $time);
        errors++;
      end else begin
        e = expected_mixes.pop_front();
        if (e.thr[0] !== out_ch.throttle_m0 || e.thr[1] !== out_ch.throttle_m1 ||
            e.thr[2] !== out_ch.throttle_m2 || e.thr[3] !== out_ch.throttle_m3) begin
          $display("%0t throttle exp %h %h %h %h got %h %h %h %h", $time, e.thr[0], e.thr[1],
                   e.thr[2], e.thr[3], out_ch.throttle_m0, out_ch.throttle_m1,
                   out_ch.throttle_m2, out_ch.throttle_m3);
          errors++;
        end
        if (e.nrm[0] !== out_ch.norm_roll || e.nrm[1] !== out_ch.norm_pitch ||
            e.nrm[2] !== out_ch.norm_yaw || e.nrm[3] !== out_ch.norm_thrust) begin
          $display("%0t norm exp %h %h %h %h got %h %h %h %h", $time, e.nrm[0], e.nrm[1],
                   e.nrm[2], e.nrm[3], out_ch.norm_roll, out_ch.norm_pitch,
                   out_ch.norm_yaw, out_ch.norm_thrust);
          errors++;
        end
        if (e.clamp !== out_ch.root_clamped) begin
          $display("%0t clamp exp %h got %h", $time, e.clamp, out_ch.root_clamped);
          errors++;
        end
      end
    end
  end

  // Sink side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(negedge clk);
        long_hold = 1'b0;
      end else if (sink_stall_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    repeat (30) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FAILED_MOTOR) fail_sel = v[1:0];
    else if (idx == CFG_ARMED_OFFSET) arm_off = v;
    else if (idx == CFG_SPEED_DIVISOR) divisor = v;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_mixes.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_torque();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0004_0000);
      3: return -$urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h8000_0000;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic load_store();
    for (int i = 0; i < 16; i++) send_request(1'b0, i[3:0], rand_coef(), $urandom, $urandom,
                                               $urandom, $urandom);
  endtask

  task automatic test_directed();
    logic [31:0] ext [4];
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000};
    for (int i = 0; i < 16; i++) send_request(1'b0, i[3:0], (i % 5 == 0) ? 32'h0001_0000 :
                                              32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 4; i++) send_request(1'b1, 4'hf, 32'hffff_ffff, ext[i], ext[(i+1)%4],
                                             ext[(i+2)%4], ext[(i+3)%4]);
    send_request(1'b1, 4'h0, 32'h0, 32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
                 32'hffff_0000);
    drain();
    for (int f = 1; f < 4; f++) begin
      write_reg(CFG_FAILED_MOTOR, f[15:0]);
      send_request(1'b1, 4'd0, 32'h0, 32'h0004_0000, 32'hfffc_0000, 32'h7fff_ffff,
                   32'h0009_0000);
      drain();
    end
    write_reg(CFG_FAILED_MOTOR, 16'd0);
    write_reg(CFG_ARMED_OFFSET, 16'hffff);
    write_reg(CFG_SPEED_DIVISOR, 16'd0);
    send_request(1'b1, 4'd0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h7fff_ffff);
    drain();
    write_reg(CFG_SPEED_DIVISOR, 16'hffff);
    write_reg(CFG_ARMED_OFFSET, 16'd0);
    write_reg(CFG_SPARE, 16'h1234);
    send_request(1'b1, 4'd0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h7fff_ffff);
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FAILED_MOTOR, 16'(ph % 4));
      write_reg(CFG_ARMED_OFFSET, (ph % 3 == 0) ? 16'd0 : 16'($urandom_range(0, 300)));
      write_reg(CFG_SPEED_DIVISOR, (ph == 7) ? 16'hffff : 16'($urandom_range(1, 40)));
      load_store();
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(0, 19) == 0)
          send_request(1'b0, 4'($urandom), rand_coef(), $urandom, $urandom, $urandom,
                       $urandom);
        else
          send_request(1'b1, 4'($urandom), $urandom, rand_torque(), rand_torque(),
                       rand_torque(), rand_torque());
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int n = 0; n < 60; n++)
      send_request(1'b1, 4'd0, 32'h0, rand_torque(), rand_torque(), rand_torque(),
                   rand_torque());
    drain();
  endtask

  task automatic test_streaming();
    src_idle_on = 1'b0;
    sink_stall_on = 1'b0;
    for (int n = 0; n < 150; n++)
      send_request(1'b1, 4'd0, 32'h0, rand_torque(), rand_torque(), rand_torque(),
                   rand_torque());
    drain();
  endtask

  initial begin
    wrenches_sent = 0;
    long_hold = 1'b0;
    sink_stall_on = 1'b1;
    src_idle_on = 1'b1;
    fail_sel = NO_FAILURE;
    arm_off = 0;
    divisor = 1;
    for (int i = 0; i < 16; i++) begin
      store[i] = 0;
      rom[i] = norm_coef(i);
    end
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 2'd0;
    cfg_wdata = 16'd0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.coef_index = 4'd0;
    in_ch.coef_value = 32'd0;
    in_ch.roll_torque = 32'd0;
    in_ch.pitch_torque = 32'd0;
    in_ch.yaw_torque = 32'd0;
    in_ch.thrust_cmd = 32'd0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phases();
    test_backpressure();
    test_streaming();
    repeat (40) @(negedge clk);
    $display("Covered %0d wrench samples and %0d mix results across failover settings,",
             wrenches_sent, mixes_seen);
    $display("offset and divisor extremes, stall bursts and a long output hold-off.");
    if (errors == 0 && expected_mixes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
